// ----- rtl/lwc_pkg.sv -----
// Package for the line window clipper: payload structs, defaults, register indexes,
// outcode bits and the outcode function, and the clipper state enum. No dependencies.
package lwc_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_PASSES_DEF = 8;
  localparam int CW = COORD_BITS_DEF;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam logic signed [CW-1:0] RESET_LEFT   = 16'sd0;
  localparam logic signed [CW-1:0] RESET_BOTTOM = 16'sd0;
  localparam logic signed [CW-1:0] RESET_RIGHT  = 16'sd639;
  localparam logic signed [CW-1:0] RESET_TOP    = 16'sd479;

  localparam logic [3:0] OC_TOP    = 4'd1;
  localparam logic [3:0] OC_BOTTOM = 4'd2;
  localparam logic [3:0] OC_RIGHT  = 4'd4;
  localparam logic [3:0] OC_LEFT   = 4'd8;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic                 batch_end;
  } in_item_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic                 batch_end;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] bottom;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] top;
  } window_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLASSIFY, ST_MUL, ST_DIV, ST_APPLY, ST_DONE
  } clip_state_t;

  function automatic logic [3:0] outcode(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (y > w.top)    c |= OC_TOP;
    if (y < w.bottom) c |= OC_BOTTOM;
    if (x > w.right)  c |= OC_RIGHT;
    if (x < w.left)   c |= OC_LEFT;
    return c;
  endfunction
endpackage

// ----- rtl/lwc_fifo.sv -----
// Two-entry queue between the input side and the clipper, and again before the
// result ports. Depends on nothing but its width parameter.
module lwc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !full) wp_r <= ~wp_r;
      if (rd_en && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
    end
  end
endmodule

// ----- rtl/lwc_divider.sv -----
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on nothing but its width parameters.
module lwc_divider #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);
  localparam int CNTW = $clog2(NW + 1);
  logic [NW-1:0]   q_r, q_nxt;
  logic [DW:0]     rem_r, rem_nxt;
  logic [DW-1:0]   d_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW:0]     trial;

  assign busy = (cnt_r != '0);
  assign quot = q_r;

  always_comb begin
    trial   = {rem_r[DW-1:0], q_r[NW-1]};
    rem_nxt = trial;
    q_nxt   = {q_r[NW-2:0], 1'b0};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt  = trial - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNTW'(NW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      d_r   <= den;
    end else if (busy) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

// ----- rtl/lwc_clipper.sv -----
// Back part: iterates Cohen-Sutherland passes on one segment with a single divider.
// Depends on lwc_pkg and lwc_divider.
module lwc_clipper
  import lwc_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  window_t   win,
  input  logic      job_valid,
  input  in_item_t  job,
  output logic      job_take,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_full
);
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW;
  localparam int PW = $clog2(MAX_PASSES + 1);

  clip_state_t state_r, state_nxt;
  logic signed [CW-1:0] kx_r, ky_r, ox_r, oy_r;
  logic                 be_r, vis_r;
  logic [PW-1:0]        pass_r;
  logic signed [DW-1:0] ka_r, na_r, nb_r, dn_r, bound_r;
  logic                 ybound_r, neg_r;
  logic [NW-1:0]        prod_r;
  logic                 div_start;
  logic                 div_busy;
  logic [NW-1:0]        quot;

  logic [3:0] c0, c1, diff, bsel;
  logic       o_first;
  logic signed [CW-1:0] kxs, kys, oxs, oys;
  logic signed [DW-1:0] bnd, d_na, d_nb, d_dn;
  logic [DW-1:0]        ma, mb, md;
  logic signed [DW+1:0] res_c;
  logic signed [CW-1:0] new_a;

  lwc_divider #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_r), .den(md),
    .busy(div_busy), .quot(quot)
  );

  assign ma = na_r[DW-1] ? DW'(-na_r) : DW'(na_r);
  assign mb = nb_r[DW-1] ? DW'(-nb_r) : DW'(nb_r);
  assign md = dn_r[DW-1] ? DW'(-dn_r) : DW'(dn_r);

  always_comb begin
    c0   = outcode(kx_r, ky_r, win);
    c1   = outcode(ox_r, oy_r, win);
    diff = c0 ^ c1;
    if (diff[0])      bsel = OC_TOP;
    else if (diff[1]) bsel = OC_BOTTOM;
    else if (diff[2]) bsel = OC_RIGHT;
    else              bsel = OC_LEFT;
    o_first = (c0 & bsel) != 4'd0;
    kxs = o_first ? ox_r : kx_r;
    kys = o_first ? oy_r : ky_r;
    oxs = o_first ? kx_r : ox_r;
    oys = o_first ? ky_r : oy_r;
    case (bsel)
      OC_TOP:    bnd = DW'(win.top);
      OC_BOTTOM: bnd = DW'(win.bottom);
      OC_RIGHT:  bnd = DW'(win.right);
      default:   bnd = DW'(win.left);
    endcase
    if (bsel == OC_TOP || bsel == OC_BOTTOM) begin
      d_na = DW'(oxs) - DW'(kxs);
      d_nb = bnd - DW'(kys);
      d_dn = DW'(oys) - DW'(kys);
    end else begin
      d_na = DW'(oys) - DW'(kys);
      d_nb = bnd - DW'(kxs);
      d_dn = DW'(oxs) - DW'(kxs);
    end
    // The quotient never exceeds |na|, so the low bits suffice.
    res_c = neg_r ? (DW+2)'(ka_r) - (DW+2)'(quot[DW:0])
                  : (DW+2)'(ka_r) + (DW+2)'(quot[DW:0]);
    if (dn_r == '0 || na_r == '0 || nb_r == '0) new_a = CW'(ka_r);
    else new_a = CW'(res_c);
  end

  always_comb begin
    state_nxt = state_r;
    job_take  = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    res.visible   = vis_r;
    res.first_x   = vis_r ? kx_r : '0;
    res.first_y   = vis_r ? ky_r : '0;
    res.second_x  = vis_r ? ox_r : '0;
    res.second_y  = vis_r ? oy_r : '0;
    res.batch_end = be_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_take  = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if ((c0 | c1) == 4'd0 || (c0 & c1) != 4'd0 || pass_r == PW'(MAX_PASSES))
          state_nxt = ST_DONE;
        else
          state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (!div_busy) state_nxt = ST_CLASSIFY;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (!res_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kx_r   <= job.first_x;
        ky_r   <= job.first_y;
        ox_r   <= job.second_x;
        oy_r   <= job.second_y;
        be_r   <= job.batch_end;
        pass_r <= '0;
      end
      ST_CLASSIFY: begin
        // A segment that used up all its passes is rejected even if it now fits.
        vis_r    <= ((c0 | c1) == 4'd0) && (pass_r != PW'(MAX_PASSES));
        kx_r     <= kxs;
        ky_r     <= kys;
        ox_r     <= oxs;
        oy_r     <= oys;
        ybound_r <= (bsel == OC_TOP || bsel == OC_BOTTOM);
        bound_r  <= bnd;
        ka_r     <= (bsel == OC_TOP || bsel == OC_BOTTOM) ? DW'(kxs) : DW'(kys);
        na_r     <= d_na;
        nb_r     <= d_nb;
        dn_r     <= d_dn;
      end
      ST_MUL: begin
        prod_r <= NW'(ma) * NW'(mb);
        neg_r  <= (na_r[DW-1] ^ nb_r[DW-1]) ^ dn_r[DW-1];
      end
      ST_APPLY: begin
        if (!div_busy) begin
          pass_r <= pass_r + 1'b1;
          if (ybound_r) begin
            ox_r <= new_a;
            oy_r <= CW'(bound_r);
          end else begin
            ox_r <= CW'(bound_r);
            oy_r <= new_a;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/lwc_front.sv -----
// Front part: window registers on the APB-style port and the input queue.
// Depends on lwc_pkg and lwc_fifo.
module lwc_front
  import lwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output window_t    win,
  input  logic       in_push,
  input  in_item_t   in_data,
  output logic       in_full,
  input  logic       job_take,
  output logic       job_valid,
  output in_item_t   job
);
  window_t win_r;
  logic    q_empty;
  logic [1:0] idx;

  assign win = win_r;
  assign idx = cfg_paddr[3:2];
  assign job_valid = !q_empty;

  always_comb begin
    case (idx)
      REG_LEFT:   cfg_prdata = 32'(win_r.left);
      REG_BOTTOM: cfg_prdata = 32'(win_r.bottom);
      REG_RIGHT:  cfg_prdata = 32'(win_r.right);
      default:    cfg_prdata = 32'(win_r.top);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= RESET_LEFT;
      win_r.bottom <= RESET_BOTTOM;
      win_r.right  <= RESET_RIGHT;
      win_r.top    <= RESET_TOP;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_LEFT:   win_r.left   <= cfg_pwdata[CW-1:0];
        REG_BOTTOM: win_r.bottom <= cfg_pwdata[CW-1:0];
        REG_RIGHT:  win_r.right  <= cfg_pwdata[CW-1:0];
        default:    win_r.top    <= cfg_pwdata[CW-1:0];
      endcase
    end
  end

  lwc_fifo #(.W($bits(in_item_t))) u_inq (
    .clk(clk), .rst_n(rst_n), .wr_en(in_push), .wr_data(in_data), .full(in_full),
    .rd_en(job_take), .rd_data(job), .empty(q_empty)
  );
endmodule

// ----- rtl/line_window_clipper.sv -----
// Line window clipper, top level: front (registers, input queue), clipper, result queue.
// Depends on lwc_pkg, lwc_front, lwc_clipper and lwc_fifo.
// Clips each segment to the window by Cohen-Sutherland passes, one segment at a
// time. Each boundary clip steps through classify, multiply and divider start, then
// waits on the one-bit-per-cycle divider over its 34 quotient bits; a segment gets
// at most MAX_PASSES boundary clips. A full result queue stalls the clipper as well.
// Two-entry queues on input and output let either side stall independently.
module line_window_clipper
  import lwc_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready,
  input  logic       in_push,
  input  in_item_t   in_data,
  output logic       in_full,
  input  logic       out_pop,
  output out_item_t  out_data,
  output logic       out_empty
);
  window_t   win;
  logic      job_valid, job_take, res_valid, res_full;
  in_item_t  job;
  out_item_t res;

  assign cfg_pready = 1'b1;

  lwc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .win(win), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .job_take(job_take), .job_valid(job_valid), .job(job)
  );

  lwc_clipper #(.MAX_PASSES(MAX_PASSES)) u_clip (
    .clk(clk), .rst_n(rst_n), .win(win), .job_valid(job_valid), .job(job),
    .job_take(job_take), .res_valid(res_valid), .res(res), .res_full(res_full)
  );

  lwc_fifo #(.W($bits(out_item_t))) u_outq (
    .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_data(res), .full(res_full),
    .rd_en(out_pop), .rd_data(out_data), .empty(out_empty)
  );

  a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("job taken from empty queue");
  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.visible) |-> (out_data.first_x == '0 && out_data.second_y == '0))
    else $error("rejected line carries coordinates");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_full) |=> !res_valid) else $error("result written twice");
endmodule

// ----- bench/tb.sv -----
// Testbench for line_window_clipper: random and directed segments, window register writes
// over the APB-style port, and a scoreboard class that predicts each clipped result.
// Depends on lwc_pkg and the line_window_clipper RTL.
module tb;
  import lwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PASSES = MAX_PASSES_DEF;

  class clip_scoreboard;
    out_item_t pending[$];
    int errors;
    logic signed [CW-1:0] wl, wb, wr, wt;

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_LEFT: wl = v[CW-1:0];
        REG_BOTTOM: wb = v[CW-1:0];
        REG_RIGHT: wr = v[CW-1:0];
        default: wt = v[CW-1:0];
      endcase
    endfunction

    function logic [3:0] region(longint x, longint y);
      logic [3:0] c;
      c = 4'd0;
      if (y > wt) c |= OC_TOP;
      if (y < wb) c |= OC_BOTTOM;
      if (x > wr) c |= OC_RIGHT;
      if (x < wl) c |= OC_LEFT;
      return c;
    endfunction

    // ka + trunc((oa-ka)*(bound-kb)/(ob-kb)); products fit easily in 64 bits.
    function longint cross_point(longint ka, longint oa, longint kb, longint ob,
                                 longint bound);
      longint den, num;
      den = ob - kb;
      if (den == 0) return ka;
      num = (oa - ka) * (bound - kb);
      return ka + num / den;
    endfunction

    function void note_segment(in_item_t s);
      out_item_t r;
      longint x0, y0, x1, y1, nx, ny, bound;
      logic [3:0] c0, c1, d, b;
      bit vis;
      bit o;
      vis = 0;
      x0 = s.first_x; y0 = s.first_y; x1 = s.second_x; y1 = s.second_y;
      for (int p = 0; p < PASSES; p++) begin
        c0 = region(x0, y0);
        c1 = region(x1, y1);
        if ((c0 | c1) == 0) begin
          vis = 1;
          break;
        end
        if ((c0 & c1) != 0) break;
        d = c0 ^ c1;
        if (d & OC_TOP) b = OC_TOP;
        else if (d & OC_BOTTOM) b = OC_BOTTOM;
        else if (d & OC_RIGHT) b = OC_RIGHT;
        else b = OC_LEFT;
        o = (c0 & b) ? 0 : 1;
        if (o) begin
          // second endpoint is outside, first is kept in place
          if (b == OC_TOP || b == OC_BOTTOM) begin
            bound = (b == OC_TOP) ? wt : wb;
            ny = bound; nx = cross_point(x0, x1, y0, y1, bound);
          end else begin
            bound = (b == OC_RIGHT) ? wr : wl;
            nx = bound; ny = cross_point(y0, y1, x0, x1, bound);
          end
        end else begin
          if (b == OC_TOP || b == OC_BOTTOM) begin
            bound = (b == OC_TOP) ? wt : wb;
            ny = bound; nx = cross_point(x1, x0, y1, y0, bound);
          end else begin
            bound = (b == OC_RIGHT) ? wr : wl;
            nx = bound; ny = cross_point(y1, y0, x1, x0, bound);
          end
          x0 = x1; y0 = y1;
        end
        x1 = nx; y1 = ny;
      end
      r = '0;
      r.visible = vis;
      if (vis) begin
        r.first_x = x0[CW-1:0]; r.first_y = y0[CW-1:0];
        r.second_x = x1[CW-1:0]; r.second_y = y1[CW-1:0];
      end
      r.batch_end = s.batch_end;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.visible !== e.visible) begin
        $display("%0t: visible exp %0d got %0d", $time, e.visible, a.visible); errors++;
      end
      if (a.first_x !== e.first_x) begin
        $display("%0t: first_x exp %0d got %0d", $time, e.first_x, a.first_x); errors++;
      end
      if (a.first_y !== e.first_y) begin
        $display("%0t: first_y exp %0d got %0d", $time, e.first_y, a.first_y); errors++;
      end
      if (a.second_x !== e.second_x) begin
        $display("%0t: second_x exp %0d got %0d", $time, e.second_x, a.second_x); errors++;
      end
      if (a.second_y !== e.second_y) begin
        $display("%0t: second_y exp %0d got %0d", $time, e.second_y, a.second_y); errors++;
      end
      if (a.batch_end !== e.batch_end) begin
        $display("%0t: batch_end exp %0d got %0d", $time, e.batch_end, a.batch_end); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic in_push, in_full, out_pop, out_empty;
  in_item_t in_data;
  out_item_t out_data;

  clip_scoreboard sb;
  int send_idle, recv_idle;

  line_window_clipper i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: pop at random, check on each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 0;
    else begin
      if (out_pop && !out_empty) sb.check_result(out_data);
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic signed [CW-1:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {{16{v[CW-1]}}, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, {{16{v[CW-1]}}, v});
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_window(int l, int b, int r, int t);
    write_reg(REG_LEFT, l[CW-1:0]);
    write_reg(REG_BOTTOM, b[CW-1:0]);
    write_reg(REG_RIGHT, r[CW-1:0]);
    write_reg(REG_TOP, t[CW-1:0]);
  endtask

  task automatic push_segment(int fx, int fy, int sx, int sy, bit be);
    in_item_t s;
    s.first_x = fx[CW-1:0]; s.first_y = fy[CW-1:0];
    s.second_x = sx[CW-1:0]; s.second_y = sy[CW-1:0]; s.batch_end = be;
    while ($urandom_range(99) < send_idle) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1; in_data <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_segment(s);
  endtask

  task automatic drain();
    int n;
    in_push <= 0;
    @(posedge clk);
    n = 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (800) @(posedge clk);
  endtask

  // Coordinates mostly near the window so clips happen; sometimes full range.
  function automatic int coord(int lo, int hi);
    if ($urandom_range(9) == 0) return $signed($urandom_range(65535)) - 32768;
    return lo - 200 + $urandom_range(hi - lo + 400);
  endfunction

  task automatic random_phase(int n, int l, int b, int r, int t);
    int lo, hi;
    lo = (l < b) ? l : b; hi = (r > t) ? r : t;
    if (hi < lo) begin lo = hi; hi = lo + 100; end
    for (int i = 0; i < n; i++)
      push_segment(coord(lo, hi), coord(lo, hi), coord(lo, hi), coord(lo, hi),
                   $urandom_range(1));
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    sb.wl = RESET_LEFT; sb.wb = RESET_BOTTOM; sb.wr = RESET_RIGHT; sb.wt = RESET_TOP;
    rst_n = 0; cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0;
    cfg_pwdata = 0; in_push = 0; in_data = '0; out_pop = 0;
    send_idle = 0; recv_idle = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed segments on the reset window.
    push_segment(10, 10, 600, 400, 0);         // inside
    push_segment(-100, -100, -50, -20, 1);     // trivially rejected
    push_segment(-100, 240, 800, 240, 0);      // horizontal, two clips
    push_segment(300, -500, 300, 900, 0);      // vertical across top and bottom
    push_segment(300, 900, 300, 100, 1);       // vertical, top only
    push_segment(-32768, -32768, 32767, 32767, 0);
    push_segment(32767, -32768, -32768, 32767, 1);
    push_segment(-32768, 32767, -32768, 32767, 0);
    push_segment(700, -10, 650, 500, 0);
    push_segment(-5, 470, 20, 520, 1);
    push_segment(639, 479, 0, 0, 0);
    push_segment(640, 480, -1, -1, 1);
    drain();
    // Inverted window, then the full-range window and a single-point window.
    set_window(100, 100, -100, -100);
    push_segment(0, 0, 50, 50, 0);
    push_segment(-200, 0, 200, 10, 1);
    push_segment(150, 150, -150, -150, 0);
    drain();
    set_window(-32768, -32768, 32767, 32767);
    push_segment(-32768, 0, 32767, -1, 1);
    push_segment(5, 5, 5, 5, 0);
    drain();
    set_window(32767, 32767, 32767, 32767);
    push_segment(-32768, -32768, 32767, 32767, 1);
    push_segment(32767, 0, 32767, 32767, 0);
    drain();

    send_idle = 13; recv_idle = 69;
    set_window(-50, -30, 200, 150);
    random_phase(450, -50, -30, 200, 150);
    drain();
    send_idle = 69; recv_idle = 13;
    set_window(-1000, 20, 1000, 25);
    random_phase(300, -1000, 20, 1000, 25);
    drain();
    set_window(10, 10, 9, 200);
    random_phase(100, 0, 0, 200, 200);
    drain();
    send_idle = 0; recv_idle = 0;
    set_window(-32768, -32768, 32767, 32767);
    random_phase(150, -20000, -20000, 20000, 20000);
    drain();
    set_window(0, 0, 639, 479);
    random_phase(450, 0, 0, 639, 479);
    drain();

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results missing", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
